// File: design/bgu_pkg.sv
// ----------------------------------------------------------------------------
// bgu_pkg: shared constants and types of the bilinear grid upsampler
// Grid geometry, zoom factor, datapath widths and the item that travels from
// the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package bgu_pkg;

	localparam int ZOOM       = 8;
	localparam int MAX_GRID_W = 64;
	localparam int MAX_GRID_H = 64;

	localparam int TWO_Z = 2 * ZOOM;

	// Field widths fixed by the interface.
	localparam int OPW = 1;
	localparam int GRW = 6;
	localparam int SW  = 16;
	localparam int OW  = 9;
	localparam int VW  = 24;
	localparam int CRW = 7;
	localparam int CIW = 1;

	// Operation and register index codes.
	localparam logic [OPW-1:0] OP_LOAD         = 1'b0;
	localparam logic [OPW-1:0] OP_QUERY        = 1'b1;
	localparam logic [CIW-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CIW-1:0] REG_GRID_HEIGHT = 1'b1;

	// Axis mapping: m = 2*out + 1 + ZOOM, q = floor(m / TWO_Z), f = m mod TWO_Z.
	localparam int FW    = $clog2(TWO_Z);
	localparam int WW    = $clog2(TWO_Z + 1);
	localparam int MW    = 11;
	localparam int QW    = MW - FW + 1;
	localparam int RSH   = 16;
	localparam int RCW   = 17;
	localparam int RECIP = (2 ** RSH + TWO_Z - 1) / TWO_Z;

	// Grid indexing and banking by row and column parity.
	localparam int XW         = $clog2(MAX_GRID_W);
	localparam int YW         = $clog2(MAX_GRID_H);
	localparam int IW         = (XW > YW) ? XW : YW;
	localparam int BXW        = XW - 1;
	localparam int BYW        = YW - 1;
	localparam int NBANK      = 4;
	localparam int BANK_DEPTH = (MAX_GRID_W / 2) * (MAX_GRID_H / 2);
	localparam int EXTW       = CRW + $clog2(ZOOM + 1);

	// Arithmetic widths.
	localparam int TW = SW + WW + 1;
	localparam int AW = TW + WW + 1;

	localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

	// Queue between front and back end.
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);

	typedef struct packed {
		logic            is_load;
		logic            status;
		logic [SW-1:0]   sample;
		logic [BYW-1:0]  ry_e;
		logic [BYW-1:0]  ry_o;
		logic [BXW-1:0]  cx_e;
		logic [BXW-1:0]  cx_o;
		logic            x0p;
		logic            x1p;
		logic            y0p;
		logic            y1p;
		logic [FW-1:0]   fx;
		logic [FW-1:0]   fy;
	} bgu_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} bgu_qstat_t;

endpackage

// File: design/bgu_if.sv
// ----------------------------------------------------------------------------
// bgu_if: stream channels of the bilinear grid upsampler
// Input channel carries load and query items, output channel carries results.
// ----------------------------------------------------------------------------
interface bgu_in_if;
	import bgu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OPW-1:0]        op;
	logic [GRW-1:0]        grid_row;
	logic [GRW-1:0]        grid_col;
	logic signed [SW-1:0]  sample;
	logic [OW-1:0]         out_x;
	logic [OW-1:0]         out_y;

	modport source(output valid, op, grid_row, grid_col, sample, out_x, out_y, input ready);
	modport sink(input valid, op, grid_row, grid_col, sample, out_x, out_y, output ready);
endinterface

interface bgu_out_if;
	import bgu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [VW-1:0]  value;
	logic                  status;

	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

// File: design/bgu_ram.sv
// ----------------------------------------------------------------------------
// bgu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bgu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/bgu_front.sv
// ----------------------------------------------------------------------------
// bgu_front: input stage of the bilinear grid upsampler
// Classifies each item, checks ranges, maps query coordinates to grid cells
// and weights, and assigns the four neighbours to parity banks.
// ----------------------------------------------------------------------------
module bgu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	bgu_in_if.sink               in_ch,
	input  logic [bgu_pkg::CRW-1:0] grid_width,
	input  logic [bgu_pkg::CRW-1:0] grid_height,
	input  bgu_pkg::bgu_qstat_t  qstat,
	output logic                 push,
	output bgu_pkg::bgu_item_t   push_item
);
	import bgu_pkg::*;

	localparam int CW2 = ((QW > CRW) ? QW : CRW) + 1;

	typedef struct packed {
		logic [QW-1:0] q;
		logic [FW-1:0] f;
	} axis_t;

	typedef struct packed {
		logic [IW-1:0] i0;
		logic [IW-1:0] i1;
	} pair_t;

	// Floor and fraction by reciprocal multiply with one correction step.
	function automatic axis_t map_axis(input logic [OW-1:0] o);
		logic [MW-1:0]     m;
		logic [MW+RCW-1:0] p;
		logic [QW-1:0]     q;
		logic [MW-1:0]     r;
		axis_t             a;
		m = MW'({o, 1'b0}) + MW'(1 + ZOOM);
		p = (MW+RCW)'(m) * (MW+RCW)'(RECIP);
		q = QW'(p >> RSH);
		r = m - MW'(MW'(q) * MW'(TWO_Z));
		if (r >= MW'(TWO_Z)) begin
			q = q + QW'(1);
			r = r - MW'(TWO_Z);
		end
		a.q = q;
		a.f = FW'(r);
		return a;
	endfunction

	// Neighbour indices q-1 and q, clamped to 0..dim-1.
	function automatic pair_t clamp_pair(input logic [QW-1:0] q, input logic [CRW-1:0] dim);
		logic [CW2-1:0] qe;
		logic [CW2-1:0] de;
		pair_t          p;
		qe = CW2'(q);
		de = CW2'(dim);
		if (qe == '0) begin
			p.i0 = '0;
		end else if (qe - CW2'(1) >= de) begin
			p.i0 = IW'(de - CW2'(1));
		end else begin
			p.i0 = IW'(qe - CW2'(1));
		end
		if (qe >= de) begin
			p.i1 = IW'(de - CW2'(1));
		end else begin
			p.i1 = IW'(qe);
		end
		return p;
	endfunction

	axis_t          ax, ay;
	pair_t          px, py;
	logic [XW-1:0]  x0c, x1c, lcol;
	logic [YW-1:0]  y0c, y1c, lrow;
	bgu_item_t      item_c;
	bgu_item_t      item_s1;
	logic           valid_s1;
	logic           take;

	assign in_ch.ready = !valid_s1 || !qstat.full;
	assign take        = in_ch.valid && in_ch.ready;
	assign push        = valid_s1 && !qstat.full;
	assign push_item   = item_s1;

	always_comb begin
		ax   = map_axis(in_ch.out_x);
		ay   = map_axis(in_ch.out_y);
		px   = clamp_pair(ax.q, grid_width);
		py   = clamp_pair(ay.q, grid_height);
		x0c  = px.i0[XW-1:0];
		x1c  = px.i1[XW-1:0];
		y0c  = py.i0[YW-1:0];
		y1c  = py.i1[YW-1:0];
		lcol = XW'(in_ch.grid_col);
		lrow = YW'(in_ch.grid_row);

		item_c        = '0;
		item_c.sample = in_ch.sample;
		unique case (in_ch.op)
			OP_LOAD: begin
				item_c.is_load = 1'b1;
				item_c.status  = (CRW'(in_ch.grid_row) >= grid_height) ||
				                 (CRW'(in_ch.grid_col) >= grid_width);
				item_c.ry_e    = lrow[YW-1:1];
				item_c.ry_o    = lrow[YW-1:1];
				item_c.cx_e    = lcol[XW-1:1];
				item_c.cx_o    = lcol[XW-1:1];
				item_c.x0p     = lcol[0];
				item_c.y0p     = lrow[0];
			end
			OP_QUERY: begin
				item_c.is_load = 1'b0;
				item_c.status  = (EXTW'(in_ch.out_x) >= EXTW'(grid_width) * EXTW'(ZOOM)) ||
				                 (EXTW'(in_ch.out_y) >= EXTW'(grid_height) * EXTW'(ZOOM));
				item_c.cx_e    = x0c[0] ? x1c[XW-1:1] : x0c[XW-1:1];
				item_c.cx_o    = x0c[0] ? x0c[XW-1:1] : x1c[XW-1:1];
				item_c.ry_e    = y0c[0] ? y1c[YW-1:1] : y0c[YW-1:1];
				item_c.ry_o    = y0c[0] ? y0c[YW-1:1] : y1c[YW-1:1];
				item_c.x0p     = x0c[0];
				item_c.x1p     = x1c[0];
				item_c.y0p     = y0c[0];
				item_c.y1p     = y1c[0];
				item_c.fx      = ax.f;
				item_c.fy      = ay.f;
			end
			default: begin
				item_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_c;
		end
	end
endmodule

// File: design/bgu_queue.sv
// ----------------------------------------------------------------------------
// bgu_queue: short item queue between front and back end
// A small circular buffer that decouples the two halves of the pipeline.
// ----------------------------------------------------------------------------
module bgu_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bgu_pkg::bgu_item_t  push_item,
	input  logic                pop,
	output bgu_pkg::bgu_item_t  pop_item,
	output bgu_pkg::bgu_qstat_t qstat
);
	import bgu_pkg::*;

	bgu_item_t        mem_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     count_q;

	assign qstat.full  = (count_q == (QPW+1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

// File: design/bgu_back.sv
// ----------------------------------------------------------------------------
// bgu_back: execution stage of the bilinear grid upsampler
// Writes loads into the four parity banks, reads the four neighbours of a
// query, forms the horizontal and then the vertical weighted sums.
// ----------------------------------------------------------------------------
module bgu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bgu_pkg::bgu_qstat_t qstat,
	output logic                pop,
	input  bgu_pkg::bgu_item_t  pop_item,
	bgu_out_if.source           out_ch
);
	import bgu_pkg::*;

	localparam int BAW = $clog2(BANK_DEPTH);

	logic                  en;
	logic [SW-1:0]         rdata [NBANK];
	logic signed [SW-1:0]  v00, v01, v10, v11;
	logic [WW-1:0]         wx0, wx1, wy0, wy1;
	logic signed [TW-1:0]  top_c, bot_c;
	logic signed [AW-1:0]  acc_c;
	logic signed [VW-1:0]  sat_c;

	bgu_item_t             item_s2;
	logic                  valid_s2;
	logic                  valid_s3;
	logic signed [TW-1:0]  top_s3, bot_s3;
	logic [FW-1:0]         fy_s3;
	logic                  zero_s3, status_s3;
	logic                  valid_s4;
	logic signed [VW-1:0]  value_s4;
	logic                  status_s4;

	assign en  = !valid_s4 || out_ch.ready;
	assign pop = en && !qstat.empty;

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		localparam logic [1:0] BID = 2'(b);
		logic [BAW-1:0] addr;

		assign addr = {(BID[1] ? pop_item.ry_o : pop_item.ry_e),
		               (BID[0] ? pop_item.cx_o : pop_item.cx_e)};

		bgu_ram #(
			.WIDTH(SW),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (pop && pop_item.is_load && !pop_item.status &&
			       ({pop_item.y0p, pop_item.x0p} == BID)),
			.waddr(addr),
			.wdata(pop_item.sample),
			.re   (pop && !pop_item.is_load),
			.raddr(addr),
			.rdata(rdata[b])
		);
	end

	always_comb begin
		v00   = $signed(rdata[{item_s2.y0p, item_s2.x0p}]);
		v01   = $signed(rdata[{item_s2.y0p, item_s2.x1p}]);
		v10   = $signed(rdata[{item_s2.y1p, item_s2.x0p}]);
		v11   = $signed(rdata[{item_s2.y1p, item_s2.x1p}]);
		wx1   = WW'(item_s2.fx);
		wx0   = WW'(TWO_Z) - wx1;
		top_c = TW'(v00) * $signed(TW'(wx0)) + TW'(v01) * $signed(TW'(wx1));
		bot_c = TW'(v10) * $signed(TW'(wx0)) + TW'(v11) * $signed(TW'(wx1));

		wy1   = WW'(fy_s3);
		wy0   = WW'(TWO_Z) - wy1;
		acc_c = AW'(top_s3) * $signed(AW'(wy0)) + AW'(bot_s3) * $signed(AW'(wy1));
		priority if (acc_c > AW'(VAL_MAX)) begin
			sat_c = VAL_MAX;
		end else if (acc_c < AW'(VAL_MIN)) begin
			sat_c = VAL_MIN;
		end else begin
			sat_c = VW'(acc_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= pop;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2   <= pop_item;
			top_s3    <= top_c;
			bot_s3    <= bot_c;
			fy_s3     <= item_s2.fy;
			zero_s3   <= item_s2.is_load || item_s2.status;
			status_s3 <= item_s2.status;
			value_s4  <= zero_s3 ? '0 : sat_c;
			status_s4 <= status_s3;
		end
	end

	assign out_ch.valid  = valid_s4;
	assign out_ch.value  = value_s4;
	assign out_ch.status = status_s4;
endmodule

// File: design/bilinear_grid_upsampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_grid_upsampler_top: bilinear grid upsampler
// Stores a signed sample grid and returns bilinear upscaled pixels with
// half-pixel centers, one result per item.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while its queue is not full, and
// returns exactly one result per item, in order. A load item writes one grid
// sample and reports whether its row and column lie inside the configured
// grid. A query item names an output pixel of the grid scaled up by ZOOM and
// returns the exact bilinear sum in units of 1/(2*ZOOM)^2 of a sample,
// saturated to 24 bits. The one-per-cycle rate is set by the grid memory: it
// is split into four banks by row and column parity, so the four neighbours
// of a query lie in different banks, or share one entry where they clamp at
// the grid edge, and are read in parallel, and a load uses one write port. A
// load is seen by every query that follows it. Configuration writes are taken
// at any time but should only be made while the block is idle; reading a grid
// entry that was never loaded returns an undefined value.
module bilinear_grid_upsampler_top (
	input  logic                   clk,
	input  logic                   arst_n,
	bgu_in_if.sink                 in_ch,
	bgu_out_if.source              out_ch,
	input  logic                   cfg_we,
	input  logic [bgu_pkg::CIW-1:0] cfg_index,
	input  logic [bgu_pkg::CRW-1:0] cfg_data
);
	import bgu_pkg::*;

	localparam logic [CRW-1:0] MAX_W_R = CRW'(MAX_GRID_W);
	localparam logic [CRW-1:0] MAX_H_R = CRW'(MAX_GRID_H);
	localparam logic [CRW-1:0] RST_W   = (MAX_GRID_W < 64) ? MAX_W_R : CRW'(64);
	localparam logic [CRW-1:0] RST_H   = (MAX_GRID_H < 64) ? MAX_H_R : CRW'(64);

	// Saturate a written size into 1..limit.
	function automatic logic [CRW-1:0] sat_reg(input logic [CRW-1:0] v,
	                                           input logic [CRW-1:0] lim);
		logic [CRW-1:0] r;
		priority if (v == '0) begin
			r = CRW'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [CRW-1:0] grid_width_q;
	logic [CRW-1:0] grid_height_q;
	logic           q_push;
	logic           q_pop;
	bgu_item_t      q_in_item;
	bgu_item_t      q_out_item;
	bgu_qstat_t     qstat;

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RST_W;
			grid_height_q <= RST_H;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH: begin
					grid_width_q <= sat_reg(cfg_data, MAX_W_R);
				end
				REG_GRID_HEIGHT: begin
					grid_height_q <= sat_reg(cfg_data, MAX_H_R);
				end
				default: begin
				end
			endcase
		end
	end

	// The front end checks ranges and computes cell indices and weights.
	bgu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.grid_width (grid_width_q),
		.grid_height(grid_height_q),
		.qstat      (qstat),
		.push       (q_push),
		.push_item  (q_in_item)
	);

	// The queue lets the front end keep accepting while the output stalls, until it fills.
	bgu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_in_item),
		.pop      (q_pop),
		.pop_item (q_out_item),
		.qstat    (qstat)
	);

	// The back end owns the grid banks and the multiply-accumulate stages.
	bgu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.pop     (q_pop),
		.pop_item(q_out_item),
		.out_ch  (out_ch)
	);

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && qstat.full))
		else $error("queue push while full");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && qstat.empty))
		else $error("queue pop while empty");

	// A result with error status always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |-> (out_ch.value == '0))
		else $error("error result with nonzero value");
endmodule

// File: sim/tb_bilinear_grid_upsampler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_grid_upsampler_top: self-checking bench of the grid upsampler
// Loads sample grids under several geometries and queries upscaled pixels.
// Every result is compared against a bilinear predictor held in the bench.
// Random stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb_bilinear_grid_upsampler_top;
	import bgu_pkg::*;

	// One input item as the bench builds it.
	typedef struct {
		logic [OPW-1:0]       op;
		logic [GRW-1:0]       grid_row;
		logic [GRW-1:0]       grid_col;
		logic signed [SW-1:0] sample;
		logic [OW-1:0]        out_x;
		logic [OW-1:0]        out_y;
	} pixel_item_t;

	// One expected result.
	typedef struct {
		logic signed [VW-1:0] value;
		logic                 status;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CIW-1:0] cfg_index = REG_GRID_WIDTH;
	logic [CRW-1:0] cfg_data = '0;

	bgu_in_if  in_ch();
	bgu_out_if out_ch();

	bilinear_grid_upsampler_top DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// The bench keeps its own copy of the grid, of which entries have been
	// loaded, and of the two geometry registers.
	logic signed [SW-1:0] grid_copy [MAX_GRID_W*MAX_GRID_H];
	bit                   grid_loaded [MAX_GRID_W*MAX_GRID_H];
	int                   cols_in_use = MAX_GRID_W;
	int                   rows_in_use = MAX_GRID_H;

	pixel_result_t pending_pixels[$];
	int  mismatches = 0;
	int  results_seen = 0;
	int  loads_sent = 0;
	int  queries_sent = 0;
	int  errors_seen = 0;
	bit  quiet = 1'b0;
	int  out_stall = 0;

	// Maps an output coordinate onto the grid: floor index, fraction in units
	// of 1/(2*ZOOM), and both neighbour indices clamped to the grid edge.
	function automatic void map_coord(input int o, input int lim,
			output int i0, output int i1, output int f);
		int n;
		n = 2 * o + 1 - ZOOM;
		i0 = (n >= 0) ? n / TWO_Z : -((-n + TWO_Z - 1) / TWO_Z);
		f = n - i0 * TWO_Z;
		i1 = i0 + 1;
		if (i1 < 0) i1 = 0;
		if (i1 > lim - 1) i1 = lim - 1;
		if (i0 < 0) i0 = 0;
		if (i0 > lim - 1) i0 = lim - 1;
	endfunction

	function automatic bit in_image(input int ox, input int oy);
		return ox < cols_in_use * ZOOM && oy < rows_in_use * ZOOM;
	endfunction

	// Returns 1 when every neighbour of an in-image query has been loaded, or
	// else the index of one missing neighbour through miss.
	function automatic bit neighbours_loaded(input int ox, input int oy, output int miss);
		int x0, x1, fx, y0, y1, fy;
		int idx[4];
		map_coord(ox, cols_in_use, x0, x1, fx);
		map_coord(oy, rows_in_use, y0, y1, fy);
		idx = '{y0 * MAX_GRID_W + x0, y0 * MAX_GRID_W + x1,
			y1 * MAX_GRID_W + x0, y1 * MAX_GRID_W + x1};
		foreach (idx[k]) begin
			if (!grid_loaded[idx[k]]) begin
				miss = idx[k];
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Bilinear predictor: updates the grid copy on loads, returns the result.
	function automatic pixel_result_t predict_pixel(input pixel_item_t it);
		pixel_result_t r;
		int x0, x1, fx, y0, y1, fy;
		longint top, bot, acc;
		r.value = '0;
		r.status = 1'b0;
		if (it.op == OP_LOAD) begin
			if (it.grid_row >= rows_in_use || it.grid_col >= cols_in_use) begin
				r.status = 1'b1;
			end else begin
				grid_copy[it.grid_row * MAX_GRID_W + it.grid_col] = it.sample;
				grid_loaded[it.grid_row * MAX_GRID_W + it.grid_col] = 1'b1;
			end
			return r;
		end
		if (!in_image(it.out_x, it.out_y)) begin
			r.status = 1'b1;
			return r;
		end
		map_coord(it.out_x, cols_in_use, x0, x1, fx);
		map_coord(it.out_y, rows_in_use, y0, y1, fy);
		top = (TWO_Z - fx) * longint'(grid_copy[y0 * MAX_GRID_W + x0])
			+ fx * longint'(grid_copy[y0 * MAX_GRID_W + x1]);
		bot = (TWO_Z - fx) * longint'(grid_copy[y1 * MAX_GRID_W + x0])
			+ fx * longint'(grid_copy[y1 * MAX_GRID_W + x1]);
		acc = (TWO_Z - fy) * top + fy * bot;
		if (acc > longint'(VAL_MAX)) acc = VAL_MAX;
		if (acc < longint'(VAL_MIN)) acc = VAL_MIN;
		r.value = acc[VW-1:0];
		return r;
	endfunction

	// Drives one item and holds it until the transfer happens. Valid stays
	// high when the next item follows at once, so it is never dropped and
	// raised within one time step.
	task automatic send_item(input pixel_item_t it);
		in_ch.valid    <= 1'b1;
		in_ch.op       <= it.op;
		in_ch.grid_row <= it.grid_row;
		in_ch.grid_col <= it.grid_col;
		in_ch.sample   <= it.sample;
		in_ch.out_x    <= it.out_x;
		in_ch.out_y    <= it.out_y;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_pixels.insert(pending_pixels.size(), predict_pixel(it));
		if (it.op == OP_LOAD) loads_sent++;
		else queries_sent++;
		// Now and then the sender idles for a random burst.
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Drops valid, then waits until every outstanding result has returned
	// plus the pipeline latency, so that the block is idle.
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Writes one geometry register and mirrors its saturation in the bench.
	// The write enable is dropped again before the task returns, so that
	// back-to-back writes never assign it twice in one time step.
	task automatic write_reg(input logic [CIW-1:0] idx, input logic [CRW-1:0] data);
		int v;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		v = (data < 1) ? 1 : data;
		if (idx == REG_GRID_WIDTH) cols_in_use = (v > MAX_GRID_W) ? MAX_GRID_W : v;
		else rows_in_use = (v > MAX_GRID_H) ? MAX_GRID_H : v;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int w, input int h);
		wait_drain();
		write_reg(REG_GRID_WIDTH, CRW'(w));
		write_reg(REG_GRID_HEIGHT, CRW'(h));
	endtask

	function automatic pixel_item_t make_load(input int row, input int col,
			input logic signed [SW-1:0] s);
		pixel_item_t it;
		it.op = OP_LOAD;
		it.grid_row = GRW'(row);
		it.grid_col = GRW'(col);
		it.sample = s;
		it.out_x = OW'($urandom);
		it.out_y = OW'($urandom);
		return it;
	endfunction

	function automatic pixel_item_t make_query(input int ox, input int oy);
		pixel_item_t it;
		it.op = OP_QUERY;
		it.grid_row = GRW'($urandom);
		it.grid_col = GRW'($urandom);
		it.sample = SW'($urandom);
		it.out_x = OW'(ox);
		it.out_y = OW'(oy);
		return it;
	endfunction

	// Random sample, biased now and then toward the extremes.
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return SW'($urandom);
		endcase
	endfunction

	// Sends a query, or when a neighbour is still unloaded, the load that
	// fills it, so that no query ever reads an unloaded entry.
	task automatic send_query_or_fill(input int ox, input int oy);
		int miss;
		if (in_image(ox, oy) && !neighbours_loaded(ox, oy, miss))
			send_item(make_load(miss / MAX_GRID_W, miss % MAX_GRID_W, pick_sample()));
		else
			send_item(make_query(ox, oy));
	endtask

	// Corners of the full-size grid after reset: the edge pixels clamp both
	// neighbours onto the corner entry, and the largest coordinates are used.
	task automatic test_reset_corners();
		send_item(make_load(0, 0, 16'sh7FFF));
		send_item(make_load(0, 63, 16'sh8000));
		send_item(make_load(63, 0, 16'sh1234));
		send_item(make_load(63, 63, -16'sh0001));
		send_item(make_query(0, 0));
		send_item(make_query(511, 0));
		send_item(make_query(0, 511));
		send_item(make_query(511, 511));
	endtask

	// Small grid with extreme samples, so that the weighted sum reaches the
	// ends of its range, plus loads and queries just outside the grid.
	task automatic test_extremes_and_bounds();
		set_geometry(2, 2);
		send_item(make_load(0, 0, 16'sh7FFF));
		send_item(make_load(0, 1, 16'sh7FFF));
		send_item(make_load(1, 0, 16'sh8000));
		send_item(make_load(1, 1, 16'sh8000));
		send_item(make_query(4, 4));
		send_item(make_query(0, 0));
		send_item(make_query(15, 15));
		send_item(make_query(8, 7));
		send_item(make_load(2, 0, 16'sh5555));
		send_item(make_load(0, 2, 16'sh5555));
		send_item(make_query(16, 0));
		send_item(make_query(0, 16));
		// A width of zero saturates up to one and an overlarge height down to
		// the maximum.
		set_geometry(0, 127);
		send_item(make_query(7, 511));
		send_item(make_query(8, 0));
		send_item(make_load(63, 1, 16'sh0042));
	endtask

	// Random traffic under one geometry: mostly well-formed queries over the
	// image, some in-grid loads, and some items with any field value at all.
	task automatic test_random_phase(input int count);
		int ox, oy;
		repeat (count) begin
			case ($urandom_range(0, 19))
				0, 1, 2: send_item(make_load($urandom_range(0, rows_in_use - 1),
					$urandom_range(0, cols_in_use - 1), pick_sample()));
				3: send_item(make_load($urandom, $urandom, pick_sample()));
				4: send_query_or_fill($urandom_range(0, 511), $urandom_range(0, 511));
				default: begin
					ox = $urandom_range(0, cols_in_use * ZOOM - 1);
					oy = $urandom_range(0, rows_in_use * ZOOM - 1);
					send_query_or_fill(ox, oy);
				end
			endcase
		end
	endtask

	// Output side: ready drops for random bursts except in the quiet part.
	always @(posedge clk) begin
		if (quiet) begin
			out_ch.ready <= 1'b1;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= $urandom_range(1, 17) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result value=%0d status=%0b",
						$realtime, out_ch.value, out_ch.status);
			end else begin
				want = pending_pixels.pop_front();
				if (out_ch.status !== want.status || out_ch.value !== want.value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result mismatch: expected value=%0d status=%0b, got value=%0d status=%0b",
							$realtime, want.value, want.status, out_ch.value, out_ch.status);
				end
				if (want.status) errors_seen++;
			end
		end
	end

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_LOAD;
		in_ch.grid_row <= '0;
		in_ch.grid_col <= '0;
		in_ch.sample <= '0;
		in_ch.out_x <= '0;
		in_ch.out_y <= '0;
		foreach (grid_loaded[k]) grid_loaded[k] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_corners();
		test_extremes_and_bounds();
		set_geometry(1, 1);
		test_random_phase(60);
		set_geometry(5, 3);
		test_random_phase(200);
		set_geometry(64, 64);
		test_random_phase(120);
		set_geometry($urandom_range(1, 12), $urandom_range(1, 12));
		test_random_phase(200);
		// The sender holds off until every result is back, then resumes.
		wait_drain();
		test_random_phase(150);
		set_geometry($urandom_range(0, 127), $urandom_range(1, 9));
		test_random_phase(150);
		set_geometry(7, 9);
		quiet = 1'b1;
		test_random_phase(200);
		wait_drain();

		$display("Run covered %0d loads and %0d queries, %0d results with %0d error statuses.",
			loads_sent, queries_sent, results_seen, errors_seen);
		$display("Geometries from 1x1 up to 64x64, with saturated register writes.");
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_pixels.size());
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", pending_pixels.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
design/bgu_pkg.sv
design/bgu_if.sv
design/bgu_ram.sv
design/bgu_front.sv
design/bgu_queue.sv
design/bgu_back.sv
design/bilinear_grid_upsampler_top.sv
sim/tb_bilinear_grid_upsampler_top.sv
